### hdl/lbcd_pkg.sv
// Shared constants and the sequencer state type for the LRU block cache directory.
// No dependencies.
package lbcd_pkg;

    localparam int CACHE_ENTRIES_DEF = 8192;
    localparam int BUCKET_COUNT_DEF  = 4096;
    localparam int TAG_W             = 32;
    localparam int COUNT_W           = 40;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_HEAD_RD,
        ST_LOOK,
        ST_CMP,
        ST_PRD,
        ST_P1,
        ST_P2,
        ST_MRD,
        ST_M1,
        ST_MW,
        ST_UNL,
        ST_L1,
        ST_L2,
        ST_L3,
        ST_DONE
    } t_state;

endpackage

### hdl/lbcd_if.sv
// Request and response channel interfaces of the LRU block cache directory.
// Depends on lbcd_pkg.
interface lbcd_req_if;
    logic                         valid;
    logic                         ready;
    logic [lbcd_pkg::TAG_W-1:0]   block_number;

    modport source (output valid, output block_number, input ready);
    modport sink   (input valid, input block_number, output ready);
endinterface

interface lbcd_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         was_hit;
    logic [lbcd_pkg::COUNT_W-1:0] hit_count;
    logic [lbcd_pkg::COUNT_W-1:0] miss_count;

    modport source (output valid, output was_hit, output hit_count, output miss_count,
                    input ready);
    modport sink   (input valid, input was_hit, input hit_count, input miss_count,
                    output ready);
endinterface

### hdl/lbcd_ram.sv
// Simple dual-port synchronous RAM: one write, one read, registered read data.
// No dependencies.
module lbcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/lbcd_mod.sv
// Bucket index unit: block number modulo the bucket count.
// Mask for a power-of-two count, else a reciprocal multiply with one correction step.
// Depends on lbcd_pkg.
module lbcd_mod #(
    parameter int BUCKET_COUNT = lbcd_pkg::BUCKET_COUNT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [lbcd_pkg::TAG_W-1:0]         i_value,
    output logic                               o_done,
    output logic [(BUCKET_COUNT > 1 ? $clog2(BUCKET_COUNT) : 1)-1:0] o_rem
);
    localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int TW = lbcd_pkg::TAG_W;

    logic r_done;
    assign o_done = r_done;

    if ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0) begin : g_mask
        logic [BW-1:0] r_rem;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_start;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_rem <= (BUCKET_COUNT > 1) ? i_value[BW-1:0] : '0;
            end
        end
        assign o_rem = r_rem;
    end else begin : g_recip
        // The quotient estimate from floor(2^32 / count) is low by at most one,
        // so one compare and subtract brings the remainder into range.
        localparam logic [2*TW-1:0] RECIP64 = (64'd1 << 32) / 64'(BUCKET_COUNT);
        localparam logic [TW-1:0]   RECIP   = RECIP64[TW-1:0];
        localparam logic [BW:0]     DIV     = (BW+1)'(BUCKET_COUNT);

        logic            r_s1, r_s2;
        logic [TW-1:0]   r_val;
        logic [2*TW-1:0] r_prod;
        logic [BW:0]     r_rem0;
        logic [BW-1:0]   r_rem;
        logic [TW-1:0]   quot, qb, diff;
        logic [BW:0]     fix;

        assign quot = r_prod[2*TW-1:TW];
        assign qb   = quot * TW'(BUCKET_COUNT);
        assign diff = r_val - qb;
        assign fix  = r_rem0 - DIV;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s1   <= 1'b0;
                r_s2   <= 1'b0;
                r_done <= 1'b0;
            end else begin
                r_s1   <= i_start;
                r_s2   <= r_s1;
                r_done <= r_s2;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_val  <= i_value;
                r_prod <= {{TW{1'b0}}, i_value} * {{TW{1'b0}}, RECIP};
            end
            if (r_s1) begin
                r_rem0 <= diff[BW:0];
            end
            if (r_s2) begin
                r_rem <= (r_rem0 >= DIV) ? fix[BW-1:0] : r_rem0[BW-1:0];
            end
        end
        assign o_rem = r_rem;
    end
endmodule

### hdl/lru_block_cache_directory.sv
// Top level of the LRU block cache directory: sequencer, pointer memories, counters.
// Depends on lbcd_pkg, lbcd_if, lbcd_ram and lbcd_mod.
//
// Usage:
//   i_req carries one block number per transfer; o_rsp returns one result per
//   request: was_hit plus the saturating hit and miss totals after that access.
//   The directory is fully associative with LRU replacement. Lookup hashes the
//   block number into a bucket chain held in memory and walks it one entry per
//   cycle; recency and chain links are doubly linked lists in block RAMs.
//   Steps from the request transfer to o_rsp.valid: bucket modulo, head read and
//   chain walk; a hit on the newest entry then ends, a hit that reorders moves
//   the entry to newest in the recency list, and a miss reads the oldest entry,
//   takes the modulo of its old tag if it was filled, unlinks it, retags it as
//   newest and links it at the head of its new bucket; a non-power-of-two bucket
//   count uses a reciprocal multiply for each modulo. The pace is set by the single
//   write port of each link memory and by the one-entry-per-cycle chain walk.
//   One item is worked at a time; the next request is taken in the cycle after the
//   result is loaded, even while that result still waits in the output register.
//   Reset: a clearing pass over max(CACHE_ENTRIES, BUCKET_COUNT) addresses writes
//   the initial recency order, empties the buckets and clears valid bits; i_req
//   stays not ready during it.
//   Stall: the result is held in an output register until o_rsp.ready; the
//   sequencer waits in its final step while that register is still full.
module lru_block_cache_directory #(
    parameter int CACHE_ENTRIES = lbcd_pkg::CACHE_ENTRIES_DEF,
    parameter int BUCKET_COUNT  = lbcd_pkg::BUCKET_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lbcd_req_if.sink      i_req,
    lbcd_rsp_if.source    o_rsp
);
    localparam int TW  = lbcd_pkg::TAG_W;
    localparam int CNW = lbcd_pkg::COUNT_W;
    localparam int IW  = $clog2(CACHE_ENTRIES);
    localparam int PW  = $clog2(CACHE_ENTRIES + 1);
    localparam int BW  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int CLR = (CACHE_ENTRIES > BUCKET_COUNT) ? CACHE_ENTRIES : BUCKET_COUNT;
    localparam int CW  = $clog2(CLR);
    localparam logic [PW-1:0]  NO_ENTRY  = PW'(CACHE_ENTRIES);
    localparam logic [CNW-1:0] COUNT_MAX = '1;

    lbcd_pkg::t_state r_state, n_state;

    // Working registers of the current item
    logic [TW-1:0]  r_tag;
    logic [BW-1:0]  r_bucket, r_obucket;
    logic [IW-1:0]  r_e, r_v, r_newest, r_oldest;
    logic [PW-1:0]  r_p, r_n;
    logic           r_vvalid, r_hit;
    logic [CNW-1:0] r_hit_total, r_miss_total;
    logic [CW-1:0]  r_clr;

    // Output register
    logic           r_ov, r_o_hit;
    logic [CNW-1:0] r_o_hc, r_o_mc;

    // Memory ports
    logic           tv_we, rn_we, rp_we, cn_we, cp_we, bh_we;
    logic [IW-1:0]  tv_wa, rn_wa, rp_wa, cn_wa, cp_wa, tv_ra, rn_ra, rp_ra, cn_ra, cp_ra;
    logic [BW-1:0]  bh_wa, bh_ra;
    logic [TW:0]    tv_wd, tv_rd;
    logic [IW-1:0]  rn_wd, rp_wd, rn_rd, rp_rd;
    logic [PW-1:0]  cn_wd, cp_wd, bh_wd, cn_rd, cp_rd, bh_rd;

    // Bucket unit
    logic           mod_start, mod_done;
    logic [TW-1:0]  mod_value;
    logic [BW-1:0]  mod_rem;

    logic           req_take, out_load, tag_match, walk_on;
    logic [PW-1:0]  walk_ptr;
    logic [IW-1:0]  clr_idx;

    assign req_take  = i_req.valid && i_req.ready;
    assign out_load  = (r_state == lbcd_pkg::ST_DONE) && (!r_ov || o_rsp.ready);
    assign tag_match = tv_rd[TW] && (tv_rd[TW-1:0] == r_tag);
    assign walk_ptr  = (r_state == lbcd_pkg::ST_LOOK) ? bh_rd : cn_rd;
    assign walk_on   = walk_ptr < NO_ENTRY;
    assign clr_idx   = r_clr[IW-1:0];

    lbcd_ram #(.WIDTH(TW + 1), .DEPTH(CACHE_ENTRIES)) u_tag_ram (
        .i_clk(i_clk), .i_we(tv_we), .i_waddr(tv_wa), .i_wdata(tv_wd),
        .i_raddr(tv_ra), .o_rdata(tv_rd));
    lbcd_ram #(.WIDTH(IW), .DEPTH(CACHE_ENTRIES)) u_rnext_ram (
        .i_clk(i_clk), .i_we(rn_we), .i_waddr(rn_wa), .i_wdata(rn_wd),
        .i_raddr(rn_ra), .o_rdata(rn_rd));
    lbcd_ram #(.WIDTH(IW), .DEPTH(CACHE_ENTRIES)) u_rprev_ram (
        .i_clk(i_clk), .i_we(rp_we), .i_waddr(rp_wa), .i_wdata(rp_wd),
        .i_raddr(rp_ra), .o_rdata(rp_rd));
    lbcd_ram #(.WIDTH(PW), .DEPTH(CACHE_ENTRIES)) u_cnext_ram (
        .i_clk(i_clk), .i_we(cn_we), .i_waddr(cn_wa), .i_wdata(cn_wd),
        .i_raddr(cn_ra), .o_rdata(cn_rd));
    lbcd_ram #(.WIDTH(PW), .DEPTH(CACHE_ENTRIES)) u_cprev_ram (
        .i_clk(i_clk), .i_we(cp_we), .i_waddr(cp_wa), .i_wdata(cp_wd),
        .i_raddr(cp_ra), .o_rdata(cp_rd));
    lbcd_ram #(.WIDTH(PW), .DEPTH(BUCKET_COUNT)) u_head_ram (
        .i_clk(i_clk), .i_we(bh_we), .i_waddr(bh_wa), .i_wdata(bh_wd),
        .i_raddr(bh_ra), .o_rdata(bh_rd));

    lbcd_mod #(.BUCKET_COUNT(BUCKET_COUNT)) u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mod_start), .i_value(mod_value),
        .o_done(mod_done), .o_rem(mod_rem));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lbcd_pkg::ST_CLEAR:   if (r_clr == CW'(CLR - 1)) n_state = lbcd_pkg::ST_IDLE;
            lbcd_pkg::ST_IDLE:    if (req_take) n_state = lbcd_pkg::ST_MOD;
            lbcd_pkg::ST_MOD:     if (mod_done) n_state = lbcd_pkg::ST_HEAD_RD;
            lbcd_pkg::ST_HEAD_RD: n_state = lbcd_pkg::ST_LOOK;
            lbcd_pkg::ST_LOOK:    n_state = walk_on ? lbcd_pkg::ST_CMP : lbcd_pkg::ST_MRD;
            lbcd_pkg::ST_CMP: begin
                priority if (tag_match) begin
                    n_state = (r_e == r_newest) ? lbcd_pkg::ST_DONE : lbcd_pkg::ST_PRD;
                end else if (!walk_on) begin
                    n_state = lbcd_pkg::ST_MRD;
                end
            end
            lbcd_pkg::ST_PRD:     n_state = lbcd_pkg::ST_P1;
            lbcd_pkg::ST_P1:      n_state = lbcd_pkg::ST_P2;
            lbcd_pkg::ST_P2:      n_state = lbcd_pkg::ST_DONE;
            lbcd_pkg::ST_MRD:     n_state = lbcd_pkg::ST_M1;
            lbcd_pkg::ST_M1:      n_state = tv_rd[TW] ? lbcd_pkg::ST_MW : lbcd_pkg::ST_UNL;
            lbcd_pkg::ST_MW:      if (mod_done) n_state = lbcd_pkg::ST_UNL;
            lbcd_pkg::ST_UNL:     n_state = lbcd_pkg::ST_L1;
            lbcd_pkg::ST_L1:      n_state = lbcd_pkg::ST_L2;
            lbcd_pkg::ST_L2:      n_state = lbcd_pkg::ST_L3;
            lbcd_pkg::ST_L3:      n_state = lbcd_pkg::ST_DONE;
            lbcd_pkg::ST_DONE:    if (out_load) n_state = lbcd_pkg::ST_IDLE;
            default:              n_state = lbcd_pkg::ST_CLEAR;
        endcase
    end

    // Memory control and outputs
    always_comb begin
        tv_we = 1'b0; rn_we = 1'b0; rp_we = 1'b0; cn_we = 1'b0; cp_we = 1'b0; bh_we = 1'b0;
        tv_wa = r_v;  rn_wa = r_v;  rp_wa = r_v;  cn_wa = r_v;  cp_wa = r_v;
        bh_wa = r_bucket;
        tv_wd = {1'b1, r_tag};
        rn_wd = r_newest; rp_wd = r_v;
        cn_wd = r_n; cp_wd = r_p; bh_wd = r_n;
        tv_ra = r_e; rn_ra = r_e; rp_ra = r_e; cn_ra = r_e; cp_ra = r_e;
        bh_ra = r_bucket;
        mod_start = 1'b0;
        mod_value = i_req.block_number;
        unique case (r_state)
            lbcd_pkg::ST_CLEAR: begin
                // Initial order: newest is the top entry, each points to the next lower one
                tv_we = {1'b0, r_clr} < (CW + 1)'(CACHE_ENTRIES);
                rn_we = tv_we;
                rp_we = tv_we;
                bh_we = {1'b0, r_clr} < (CW + 1)'(BUCKET_COUNT);
                tv_wa = clr_idx; rn_wa = clr_idx; rp_wa = clr_idx;
                bh_wa = r_clr[BW-1:0];
                tv_wd = '0;
                rn_wd = (clr_idx == '0) ? '0 : clr_idx - 1'b1;
                rp_wd = (clr_idx == IW'(CACHE_ENTRIES - 1)) ? clr_idx : clr_idx + 1'b1;
                bh_wd = NO_ENTRY;
            end
            lbcd_pkg::ST_IDLE: mod_start = req_take;
            lbcd_pkg::ST_LOOK, lbcd_pkg::ST_CMP: begin
                tv_ra = walk_ptr[IW-1:0];
                cn_ra = walk_ptr[IW-1:0];
            end
            lbcd_pkg::ST_P1: begin
                // Unlink the hit entry from the recency list
                rn_we = 1'b1;
                rn_wa = rp_rd;
                rn_wd = rn_rd;
                rp_we = r_e != r_oldest;
                rp_wa = rn_rd;
                rp_wd = rp_rd;
            end
            lbcd_pkg::ST_P2: begin
                rn_we = 1'b1; rn_wa = r_e;      rn_wd = r_newest;
                rp_we = 1'b1; rp_wa = r_newest; rp_wd = r_e;
            end
            lbcd_pkg::ST_MRD: begin
                tv_ra = r_oldest; rp_ra = r_oldest; cp_ra = r_oldest; cn_ra = r_oldest;
            end
            lbcd_pkg::ST_M1: begin
                mod_start = tv_rd[TW];
                mod_value = tv_rd[TW-1:0];
            end
            lbcd_pkg::ST_UNL: begin
                // Drop the victim from its old chain, retag it, make it newest
                bh_we = r_vvalid && (r_p >= NO_ENTRY);
                bh_wa = r_obucket;
                bh_wd = r_n;
                cn_we = r_vvalid && (r_p < NO_ENTRY);
                cn_wa = r_p[IW-1:0];
                cp_we = r_vvalid && (r_n < NO_ENTRY);
                cp_wa = r_n[IW-1:0];
                tv_we = 1'b1;
                rn_we = 1'b1; rn_wa = r_v;      rn_wd = r_newest;
                rp_we = 1'b1; rp_wa = r_newest; rp_wd = r_v;
            end
            lbcd_pkg::ST_L2: begin
                // Link the victim at the head of its new bucket
                cn_we = 1'b1; cn_wa = r_v; cn_wd = bh_rd;
                cp_we = 1'b1; cp_wa = r_v; cp_wd = NO_ENTRY;
                bh_we = 1'b1; bh_wd = {{(PW - IW){1'b0}}, r_v};
            end
            lbcd_pkg::ST_L3: begin
                cp_we = r_n < NO_ENTRY;
                cp_wa = r_n[IW-1:0];
                cp_wd = {{(PW - IW){1'b0}}, r_v};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lbcd_pkg::ST_CLEAR;
            r_clr        <= '0;
            r_newest     <= IW'(CACHE_ENTRIES - 1);
            r_oldest     <= '0;
            r_hit_total  <= '0;
            r_miss_total <= '0;
            r_ov         <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lbcd_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == lbcd_pkg::ST_P1 && r_e == r_oldest) begin
                r_oldest <= rp_rd;
            end
            if (r_state == lbcd_pkg::ST_P2) begin
                r_newest <= r_e;
            end
            if (r_state == lbcd_pkg::ST_M1) begin
                r_oldest <= rp_rd;
            end
            if (r_state == lbcd_pkg::ST_UNL) begin
                r_newest <= r_v;
            end
            if (r_state == lbcd_pkg::ST_CMP && tag_match) begin
                if (r_hit_total != COUNT_MAX) r_hit_total <= r_hit_total + 1'b1;
            end
            if (n_state == lbcd_pkg::ST_MRD && r_state != lbcd_pkg::ST_MRD) begin
                if (r_miss_total != COUNT_MAX) r_miss_total <= r_miss_total + 1'b1;
            end
            // Output register: load from the final step, drop on transfer
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_tag <= i_req.block_number;
        end
        if (r_state == lbcd_pkg::ST_MOD && mod_done) begin
            r_bucket <= mod_rem;
        end
        if (r_state == lbcd_pkg::ST_MW && mod_done) begin
            r_obucket <= mod_rem;
        end
        if ((r_state == lbcd_pkg::ST_LOOK || r_state == lbcd_pkg::ST_CMP) && walk_on) begin
            r_e <= walk_ptr[IW-1:0];
        end
        if (r_state == lbcd_pkg::ST_CMP && tag_match) begin
            r_hit <= 1'b1;
            r_e   <= r_e;
        end
        if (r_state == lbcd_pkg::ST_LOOK || r_state == lbcd_pkg::ST_CMP) begin
            if (!(r_state == lbcd_pkg::ST_CMP && tag_match)) r_hit <= 1'b0;
        end
        if (r_state == lbcd_pkg::ST_MRD) begin
            r_v <= r_oldest;
        end
        if (r_state == lbcd_pkg::ST_M1) begin
            r_vvalid <= tv_rd[TW];
            r_p      <= cp_rd;
            r_n      <= cn_rd;
        end
        if (r_state == lbcd_pkg::ST_L2) begin
            r_n <= bh_rd;
        end
        if (out_load) begin
            r_o_hit <= r_hit;
            r_o_hc  <= r_hit_total;
            r_o_mc  <= r_miss_total;
        end
    end

    assign i_req.ready      = (r_state == lbcd_pkg::ST_IDLE);
    assign o_rsp.valid      = r_ov;
    assign o_rsp.was_hit    = r_o_hit;
    assign o_rsp.hit_count  = r_o_hc;
    assign o_rsp.miss_count = r_o_mc;
endmodule

### hdl/lbcd_checker.sv
// Port-level checks for the LRU block cache directory, bound to the top level.
// Depends on lbcd_pkg.
module lbcd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_was_hit,
    input logic [lbcd_pkg::COUNT_W-1:0] i_hit_count,
    input logic [lbcd_pkg::COUNT_W-1:0] i_miss_count
);
    // Result held while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_hit_count)
            && $stable(i_miss_count) && $stable(i_was_hit))
        else $error("result changed while stalled");

    // A hit result always carries a nonzero hit total, a miss a nonzero miss total
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_was_hit ? (i_hit_count != '0) : (i_miss_count != '0)))
        else $error("total does not reflect result");

    // Clearing pass keeps the request side closed right after reset
    a_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("request accepted during clearing");

    // No result straight out of reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind lru_block_cache_directory lbcd_checker u_lbcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_was_hit   (o_rsp.was_hit),
    .i_hit_count (o_rsp.hit_count),
    .i_miss_count(o_rsp.miss_count)
);

### dv/lbcd_dir_checker.sv
// Watches the request and response channels of the LRU block cache directory, predicts
// each result from a local copy of the directory and compares. Depends on lbcd_pkg, lbcd_if.
module lbcd_dir_checker #(
    parameter int CACHE_ENTRIES = lbcd_pkg::CACHE_ENTRIES_DEF,
    parameter int BUCKET_COUNT  = lbcd_pkg::BUCKET_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lbcd_req_if       req,
    lbcd_rsp_if       rsp,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NONE = CACHE_ENTRIES;
    localparam logic [lbcd_pkg::COUNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic                         was_hit;
        logic [lbcd_pkg::COUNT_W-1:0] hit_count;
        logic [lbcd_pkg::COUNT_W-1:0] miss_count;
    } t_access_result;

    logic [31:0] tag_mem [CACHE_ENTRIES];
    bit          live    [CACHE_ENTRIES];
    int          older   [CACHE_ENTRIES];
    int          newer   [CACHE_ENTRIES];
    int          nxt     [CACHE_ENTRIES];
    int          prv     [CACHE_ENTRIES];
    int          head    [BUCKET_COUNT];
    int          mru, lru;
    logic [lbcd_pkg::COUNT_W-1:0] hits, misses;
    t_access_result expected_results[$];

    function automatic void clear_directory();
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            tag_mem[i] = '0;
            live[i]    = 0;
            nxt[i]     = NONE;
            prv[i]     = NONE;
            older[i]   = (i == 0) ? 0 : i - 1;
            newer[i]   = (i + 1 < CACHE_ENTRIES) ? i + 1 : i;
        end
        for (int b = 0; b < BUCKET_COUNT; b++) head[b] = NONE;
        mru    = CACHE_ENTRIES - 1;
        lru    = 0;
        hits   = '0;
        misses = '0;
    endfunction

    function automatic int bucket(logic [31:0] t);
        return int'(t % BUCKET_COUNT);
    endfunction

    // Move an entry to the most-recent end of the recency order.
    function automatic void push_newest(int e);
        older[e]   = mru;
        newer[mru] = e;
        mru        = e;
    endfunction

    function automatic t_access_result access_block(logic [31:0] t);
        t_access_result r;
        int e, steps, v, p, n, b;
        e = head[bucket(t)];
        steps = 0;
        while (steps < CACHE_ENTRIES && e < NONE && !(live[e] && tag_mem[e] == t)) begin
            e = nxt[e];
            steps++;
        end
        if (steps >= CACHE_ENTRIES) e = NONE;
        if (e < NONE) begin
            r.was_hit = 1'b1;
            if (hits != CNT_MAX) hits++;
            if (e != mru) begin
                older_link: begin
                    older[newer[e]] = older[e];
                end
                if (e == lru) lru = newer[e];
                else newer[older[e]] = newer[e];
                push_newest(e);
            end
        end else begin
            r.was_hit = 1'b0;
            v = lru;
            if (misses != CNT_MAX) misses++;
            lru = newer[v];
            // Drop the victim from its old bucket chain; a never-filled entry has none.
            if (live[v]) begin
                p = prv[v];
                n = nxt[v];
                if (p >= NONE) head[bucket(tag_mem[v])] = n;
                else nxt[p] = n;
                if (n < NONE) prv[n] = p;
            end
            tag_mem[v] = t;
            live[v]    = 1;
            push_newest(v);
            b = bucket(t);
            nxt[v] = head[b];
            prv[v] = NONE;
            if (head[b] < NONE) prv[head[b]] = v;
            head[b] = v;
        end
        r.hit_count  = hits;
        r.miss_count = misses;
        return r;
    endfunction

    initial begin
        clear_directory();
        o_fail_count = 0;
    end

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_access_result want, got;
        if (i_rst_n) begin
            if (req.valid && req.ready)
                expected_results.push_back(access_block(req.block_number));
            if (rsp.valid && rsp.ready) begin
                got.was_hit    = rsp.was_hit;
                got.hit_count  = rsp.hit_count;
                got.miss_count = rsp.miss_count;
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result transfer: hit=%0b h=%0d m=%0d",
                                 got.was_hit, got.hit_count, got.miss_count);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: exp hit=%0b h=%0d m=%0d, got hit=%0b h=%0d m=%0d",
                                     want.was_hit, want.hit_count, want.miss_count,
                                     got.was_hit, got.hit_count, got.miss_count);
                    end
                end
            end
        end
    end
endmodule

### dv/lru_block_cache_directory_tb.sv
// Top of the LRU block cache directory testbench: clock, reset, request stimulus and
// response back-pressure. Depends on lbcd_pkg, lbcd_if, the RTL and lbcd_dir_checker.
module lru_block_cache_directory_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   stall_hold;   // long receiver hold-off is active
    bit   rsp_done;

    lbcd_req_if req();
    lbcd_rsp_if rsp();

    lru_block_cache_directory i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_rsp   (rsp.source)
    );

    lbcd_dir_checker i_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req),
        .rsp          (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // Offer one block number and hold it until the transfer happens.
    task automatic send_block(logic [31:0] blk);
        req.valid        <= 1'b1;
        req.block_number <= blk;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
    endtask

    // Send with a random gap in front; the gap drops valid only when it is non-zero.
    task automatic send_gapped(logic [31:0] blk, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            req.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        send_block(blk);
    endtask

    // Let the last transfer reach the checker, then wait for every result.
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Receiver: random ready, with stretches of always-ready and one long hold-off.
    initial begin
        int g;
        rsp.ready <= 1'b0;
        @(posedge i_clk);
        while (!rsp_done) begin
            if (stall_hold) begin
                rsp.ready <= 1'b0;
                @(posedge i_clk);
            end else begin
                g = gap_len();
                if ($urandom_range(0, 3) == 0) g = 0;
                if (g > 0) begin
                    rsp.ready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
                rsp.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [31:0] hot [16];
        logic [31:0] blk;
        int burst;
        bit quiet;
        req.valid        <= 1'b0;
        req.block_number <= '0;
        i_rst_n          <= 1'b0;
        stall_hold        = 0;
        rsp_done          = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero tag first (must miss despite cleared tags), field extremes,
        // single-bit walks, hits on newest and on older entries, bucket collisions.
        send_block(32'h0000_0000);
        send_block(32'h0000_0000);
        send_block(32'hFFFF_FFFF);
        send_block(32'h0000_0000);
        send_block(32'hFFFF_FFFF);
        for (int b = 0; b < 32; b += 4) send_gapped(32'h1 << b, 0);
        send_block(32'h0000_1000);
        send_block(32'h0000_2000);
        send_block(32'h0000_1000);
        send_block(32'h0000_3000);
        send_block(32'h0000_2000);
        send_block(32'hAAAA_AAAA);
        send_block(32'h5555_5555);
        drain();

        // Long hold-off on the result side while the sender keeps offering.
        stall_hold = 1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                stall_hold = 0;
            end
            for (int k = 0; k < 12; k++) send_block($urandom());
        join
        drain();

        // Random: mostly re-references of a hot set and a small pool, so hits come
        // often; a stretch of the items is sent with no gaps in front.
        for (int i = 0; i < 16; i++) hot[i] = $urandom();
        for (int i = 0; i < 500; i++) begin
            case ($urandom_range(0, 5))
                0, 1:    blk = hot[$urandom_range(0, 15)];
                2:       blk = {2'($urandom_range(0, 3)), 14'($urandom_range(0, 7)), 16'h0};
                3:       blk = $urandom_range(0, 63) * 32'd4096 + 32'd7;
                default: blk = $urandom();
            endcase
            if (i % 9 == 0) blk ^= 32'h1 << $urandom_range(0, 31);
            quiet = (i >= 200 && i < 260);
            send_gapped(blk, quiet);
        end
        drain();
        // Sender pause until every result has arrived, then finish with repeats.
        for (int i = 0; i < 20; i++) send_gapped(hot[i % 16], 0);
        drain();

        repeat (64) @(posedge i_clk);
        rsp_done = 1;
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Clearing pass over 8192 entries plus ~550 items; even with the longest gaps, stalls
    // and chain walks on every item the run needs well under 2 ms.
    initial begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
